### src/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg: shared types and codes for the positional list store
// Capacity, request and status codes, cell operations and the row control
// bundle that drives the chain of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam int REQ_W   = 3;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    // cell operations
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD       = 2'd0;
    localparam cell_op_t OP_LOAD       = 2'd1;
    localparam cell_op_t OP_FROM_LEFT  = 2'd2;  // take the neighbor nearer the head
    localparam cell_op_t OP_FROM_RIGHT = 2'd3;  // take the neighbor nearer the tail

    typedef logic [DATA_W-1:0] data_t;

    typedef struct packed {
        cell_op_t [CAPACITY-1:0] op;
        data_t                   load_value;
        data_t                   key;
    } row_ctl_t;

endpackage

`default_nettype wire

### src/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell: one storage cell of the list
// Holds one entry, loads a new value or takes a neighbor's entry on command,
// and flags whether its entry equals the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_cell (
    input  wire                       clk,
    input  wire plist_pkg::cell_op_t  op,
    input  wire plist_pkg::data_t     load_value,
    input  wire plist_pkg::data_t     left_value,
    input  wire plist_pkg::data_t     right_value,
    input  wire plist_pkg::data_t     key,
    output plist_pkg::data_t          entry,
    output logic                      match
);

    plist_pkg::data_t entry_reg;
    plist_pkg::data_t entry_next;

    always_comb
    begin
        unique case (op)
            plist_pkg::OP_HOLD:       entry_next = entry_reg;
            plist_pkg::OP_LOAD:       entry_next = load_value;
            plist_pkg::OP_FROM_LEFT:  entry_next = left_value;
            plist_pkg::OP_FROM_RIGHT: entry_next = right_value;
            default:                  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == key);

endmodule

`default_nettype wire

### src/plist_ctrl.sv
// ----------------------------------------------------------------------------
// plist_ctrl: request sequencer for the positional list store
// Registers a request, then in the execute cycle decodes it against the
// count and the cell match flags, commands every cell and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_ctrl (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          start,
    input  wire  [plist_pkg::REQ_W-1:0]                  req_type,
    input  wire  signed [plist_pkg::DATA_W-1:0]          item_value,
    input  wire  [plist_pkg::POS_W-1:0]                  position,
    input  wire plist_pkg::data_t [plist_pkg::CAPACITY-1:0] entries,
    input  wire  [plist_pkg::CAPACITY-1:0]               hits,
    output plist_pkg::row_ctl_t                          row_ctl,
    output logic                                         busy,
    output logic                                         done,
    output logic [plist_pkg::STAT_W-1:0]                 status,
    output logic signed [plist_pkg::DATA_W-1:0]          read_value,
    output logic [plist_pkg::OCNT_W-1:0]                 entry_count
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                              state_reg;
    logic                              done_reg;
    logic [plist_pkg::CNT_W-1:0]       count_reg;
    logic [plist_pkg::CNT_W-1:0]       count_next;
    logic [plist_pkg::REQ_W-1:0]       kind_reg;
    plist_pkg::data_t                  value_reg;
    logic [plist_pkg::POS_W-1:0]       pos_reg;
    logic [plist_pkg::STAT_W-1:0]      status_reg;
    logic [plist_pkg::STAT_W-1:0]      status_next;
    plist_pkg::data_t                  read_reg;
    plist_pkg::data_t                  read_next;

    logic                              accept;
    logic [plist_pkg::CNT_W-1:0]       posx;
    logic [plist_pkg::CAPACITY-1:0]    live_match;
    logic                              found;
    logic [plist_pkg::CNT_W-1:0]       at;
    plist_pkg::cell_op_t [plist_pkg::CAPACITY-1:0] ops;

    assign accept = start && (state_reg == S_IDLE);
    assign posx   = plist_pkg::CNT_W'(pos_reg);

    // first match from the head among the occupied cells
    always_comb
    begin
        found = 1'b0;
        at    = '0;
        for (int i = 0; i < plist_pkg::CAPACITY; i++)
        begin
            live_match[i] = hits[i] && (plist_pkg::CNT_W'(i) < count_reg);
        end
        for (int i = plist_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (live_match[i])
            begin
                found = 1'b1;
                at    = plist_pkg::CNT_W'(i);
            end
        end
    end

    always_comb
    begin
        status_next = plist_pkg::ST_OK;
        read_next   = '0;
        count_next  = count_reg;
        for (int i = 0; i < plist_pkg::CAPACITY; i++)
        begin
            ops[i] = plist_pkg::OP_HOLD;
        end

        if (state_reg == S_EXEC)
        begin
            unique case (kind_reg)
                plist_pkg::REQ_APPEND:
                begin
                    if (count_reg >= plist_pkg::CNT_W'(plist_pkg::CAPACITY))
                    begin
                        status_next = plist_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < plist_pkg::CAPACITY; i++)
                        begin
                            if (plist_pkg::CNT_W'(i) == count_reg)
                            begin
                                ops[i] = plist_pkg::OP_LOAD;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                plist_pkg::REQ_INSERT:
                begin
                    if (posx >= count_reg)
                    begin
                        status_next = plist_pkg::ST_RANGE;
                    end
                    else if (count_reg >= plist_pkg::CNT_W'(plist_pkg::CAPACITY))
                    begin
                        status_next = plist_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < plist_pkg::CAPACITY; i++)
                        begin
                            if (plist_pkg::CNT_W'(i) == posx)
                            begin
                                ops[i] = plist_pkg::OP_LOAD;
                            end
                            else if (plist_pkg::CNT_W'(i) > posx &&
                                     plist_pkg::CNT_W'(i) <= count_reg)
                            begin
                                ops[i] = plist_pkg::OP_FROM_LEFT;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                plist_pkg::REQ_DELETE:
                begin
                    if (posx >= count_reg)
                    begin
                        status_next = plist_pkg::ST_RANGE;
                    end
                    else
                    begin
                        for (int i = 0; i < plist_pkg::CAPACITY; i++)
                        begin
                            if (plist_pkg::CNT_W'(i) >= posx &&
                                plist_pkg::CNT_W'(i + 1) < count_reg)
                            begin
                                ops[i] = plist_pkg::OP_FROM_RIGHT;
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                plist_pkg::REQ_MOVE:
                begin
                    if (!found)
                    begin
                        status_next = plist_pkg::ST_MISSING;
                    end
                    else if (posx > count_reg - 1'b1)
                    begin
                        status_next = plist_pkg::ST_RANGE;
                    end
                    else
                    begin
                        // remove at the match and reinsert at the target in one shift
                        for (int i = 0; i < plist_pkg::CAPACITY; i++)
                        begin
                            if (plist_pkg::CNT_W'(i) == posx)
                            begin
                                ops[i] = plist_pkg::OP_LOAD;
                            end
                            else if (posx < at && plist_pkg::CNT_W'(i) > posx &&
                                     plist_pkg::CNT_W'(i) <= at)
                            begin
                                ops[i] = plist_pkg::OP_FROM_LEFT;
                            end
                            else if (posx > at && plist_pkg::CNT_W'(i) >= at &&
                                     plist_pkg::CNT_W'(i) < posx)
                            begin
                                ops[i] = plist_pkg::OP_FROM_RIGHT;
                            end
                        end
                    end
                end
                plist_pkg::REQ_READ:
                begin
                    if (posx >= count_reg)
                    begin
                        status_next = plist_pkg::ST_RANGE;
                    end
                    else
                    begin
                        read_next = entries[plist_pkg::IDX_W'(pos_reg)];
                    end
                end
                default:
                begin
                    status_next = plist_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (state_reg == S_EXEC)
            begin
                state_reg <= S_IDLE;
                done_reg  <= 1'b1;
                count_reg <= count_next;
            end
            else if (accept)
            begin
                state_reg <= S_EXEC;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req_type;
            value_reg <= item_value;
            pos_reg   <= position;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= status_next;
            read_reg   <= read_next;
        end
    end

    assign row_ctl.op         = ops;
    assign row_ctl.load_value = value_reg;
    assign row_ctl.key        = value_reg;

    assign busy        = (state_reg == S_EXEC);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_reg;
    assign entry_count = plist_pkg::OCNT_W'(count_reg);

endmodule

`default_nettype wire

### src/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top: ordered store of signed 32-bit values
// Append, insert, delete, move-by-value and read on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, item_value, position) is taken at a rising edge
//   where start is high and busy is low. busy is high for the one execute
//   cycle that follows. In that cycle every cell compares its entry with the
//   search key in parallel, the sequencer picks the first match, and all
//   cells shift, load or hold together at its closing edge.
//   The result (status, read_value, entry_count) appears on the following
//   cycle with done high for exactly that one cycle. A new request may be
//   started in the same cycle that done is high.
//   No new request is taken while busy is high, so the cell row executes
//   one request at a time.
//   Reset empties the store (count zero); entry contents are not cleared.
//   The receiver cannot stall: done is high for one cycle only, and status and read_value hold until the next execute.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_top (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    start,
    input  wire  [plist_pkg::REQ_W-1:0]            req_type,
    input  wire  signed [plist_pkg::DATA_W-1:0]    item_value,
    input  wire  [plist_pkg::POS_W-1:0]            position,
    output logic                                   busy,
    output logic                                   done,
    output logic [plist_pkg::STAT_W-1:0]           status,
    output logic signed [plist_pkg::DATA_W-1:0]    read_value,
    output logic [plist_pkg::OCNT_W-1:0]           entry_count
);

    plist_pkg::row_ctl_t                            row_ctl;
    plist_pkg::data_t [plist_pkg::CAPACITY-1:0]     entries;
    logic [plist_pkg::CAPACITY-1:0]                 hits;

    plist_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .item_value  (item_value),
        .position    (position),
        .entries     (entries),
        .hits        (hits),
        .row_ctl     (row_ctl),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    for (genvar i = 0; i < plist_pkg::CAPACITY; i++)
    begin : g_cell
        plist_pkg::data_t left_value;
        plist_pkg::data_t right_value;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
        end
        else
        begin : g_left
            assign left_value = entries[i-1];
        end

        if (i == plist_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_right
            assign right_value = entries[i+1];
        end

        plist_cell u_cell (
            .clk         (clk),
            .op          (row_ctl.op[i]),
            .load_value  (row_ctl.load_value),
            .left_value  (left_value),
            .right_value (right_value),
            .key         (row_ctl.key),
            .entry       (entries[i]),
            .match       (hits[i])
        );
    end

endmodule

`default_nettype wire
